// File: hw/rtl/famr_pkg.sv
// Shared types and codes for the fraction add/multiply/reduce block.
`default_nettype none

package famr_pkg;

    localparam int unsigned IN_WIDTH      = 16;
    localparam int unsigned RES_NUM_WIDTH = 33;
    localparam int unsigned RES_DEN_WIDTH = 32;

    // action field
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_MUL = 1'b1;

    // multiplier operand selection
    localparam logic [1:0] MUL_FIRST = 2'd0;  // an * bd (add) or an * bn (multiply)
    localparam logic [1:0] MUL_CROSS = 2'd1;  // bn * ad
    localparam logic [1:0] MUL_DEN   = 2'd2;  // ad * bd

    typedef struct packed {
        logic                  action;
        logic [IN_WIDTH-1:0]   a_numerator;
        logic [IN_WIDTH-1:0]   a_denominator;
        logic [IN_WIDTH-1:0]   b_numerator;
        logic [IN_WIDTH-1:0]   b_denominator;
    } famr_in_t;

    typedef struct packed {
        logic [RES_NUM_WIDTH-1:0] result_numerator;
        logic [RES_DEN_WIDTH-1:0] result_denominator;
    } famr_out_t;

    typedef struct packed {
        logic       load_in;
        logic [1:0] mul_sel;
        logic       prod_load;
        logic       num_load;
        logic       num_add;
        logic       den_load;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } famr_cmd_t;

    typedef struct packed {
        logic is_zero;   // raw numerator or denominator is zero
        logic gcd_done;  // odd part of the divisor found
        logic div_last;  // final quotient bit this cycle
    } famr_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/fraction_add_multiply_reduce.sv
// Top level: adds or multiplies two fractions and reduces the result by its GCD.
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+------------------------
//  input   | in_valid, in_ready, in_data    | in_valid && in_ready
//  output  | out_valid, out_ready, out_data | out_valid && out_ready
//
// One item at a time. An item goes through set-up and products (one shared W x W
// multiplier, three products), then the binary GCD loop at one step a cycle, then
// the bit-serial dividers. Zero numerator or denominator skips GCD and division.
// rst_n clears the controller only; a held result does not stop the next item being taken.
`default_nettype none

module fraction_add_multiply_reduce
    import famr_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire famr_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output famr_out_t     out_data
);

    famr_cmd_t cmd;
    famr_sts_t sts;

    famr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    famr_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    // a new item is never taken in the cycle after one was accepted
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // a result is only loaded into the output stage once the old one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid || out_ready)
        else $error("output result overwritten");

    // division only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !sts.is_zero)
        else $error("division with zero operand");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: hw/rtl/famr_dp.sv
// Datapath: operand capture, shared multiplier, binary GCD and twin restoring dividers.
`default_nettype none

module famr_dp
    import famr_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = 16
) (
    input  wire logic      clk,
    input  wire famr_in_t  in_data,
    input  wire famr_cmd_t cmd,
    output famr_sts_t      sts,
    output famr_out_t      out_data
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned DW = 2 * W;
    localparam int unsigned NW = 2 * W + 1;
    localparam int unsigned KW = $clog2(NW);
    localparam int unsigned CW = $clog2(NW);

    logic          act_reg, act_next;
    logic [W-1:0]  an_reg, an_next;
    logic [W-1:0]  ad_reg, ad_next;
    logic [W-1:0]  bn_reg, bn_next;
    logic [W-1:0]  bd_reg, bd_next;
    logic [DW-1:0] prod_reg, prod_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [NW-1:0] x_reg, x_next;
    logic [NW-1:0] y_reg, y_next;
    logic [KW-1:0] k_reg, k_next;
    logic [NW-1:0] qn_reg, qn_next;
    logic [NW-1:0] qd_reg, qd_next;
    logic [NW:0]   rn_reg, rn_next;
    logic [NW:0]   rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    famr_out_t     out_reg, out_next;

    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic [2*NW:0] step_n;
    logic [2*NW:0] step_d;
    logic [63:0]   qn_wide;
    logic [63:0]   qd_wide;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [2*NW:0] div_bit(
        input logic [NW:0]   rem,
        input logic [NW-1:0] quo,
        input logic [NW-1:0] dsr
    );
        logic [NW:0] trial;
        logic [NW:0] diff;
        trial = {rem[NW-1:0], quo[NW-1]};
        diff  = trial - {1'b0, dsr};
        if (trial >= {1'b0, dsr})
        begin
            return {diff, quo[NW-2:0], 1'b1};
        end
        return {trial, quo[NW-2:0], 1'b0};
    endfunction

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_FIRST:
            begin
                mul_a = an_reg;
                mul_b = (act_reg == ACT_MUL) ? bn_reg : bd_reg;
            end
            MUL_CROSS:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            MUL_DEN:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign step_n = div_bit(rn_reg, qn_reg, x_reg);
    assign step_d = div_bit(rd_reg, qd_reg, x_reg);

    assign sts.is_zero  = (num_reg == '0) || (den_reg == '0);
    assign sts.gcd_done = (x_reg == y_reg) && x_reg[0];
    assign sts.div_last = (cnt_reg == '0);

    assign qn_wide = 64'(qn_reg);
    assign qd_wide = 64'(qd_reg);

    always_comb
    begin
        act_next  = act_reg;
        an_next   = an_reg;
        ad_next   = ad_reg;
        bn_next   = bn_reg;
        bd_next   = bd_reg;
        prod_next = prod_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        qn_next   = qn_reg;
        qd_next   = qd_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        cnt_next  = cnt_reg;
        out_next  = out_reg;

        if (cmd.load_in)
        begin
            act_next = in_data.action;
            an_next  = W'(in_data.a_numerator);
            ad_next  = W'(in_data.a_denominator);
            bn_next  = W'(in_data.b_numerator);
            bd_next  = W'(in_data.b_denominator);
        end

        if (cmd.prod_load)
        begin
            prod_next = mul_a * mul_b;
        end

        if (cmd.num_load)
        begin
            num_next = NW'(prod_reg);
        end
        else if (cmd.num_add && (act_reg == ACT_ADD))
        begin
            num_next = num_reg + NW'(prod_reg);
        end

        if (cmd.den_load)
        begin
            den_next = prod_reg;
        end

        // raw values also sit in the quotient registers for the unreduced case
        if (cmd.gcd_init)
        begin
            x_next  = num_reg;
            y_next  = NW'(den_reg);
            k_next  = '0;
            qn_next = num_reg;
            qd_next = NW'(den_reg);
        end

        // binary GCD: strip common twos into k, then odd-odd subtraction
        if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_next = x_reg - y_reg;
            end
            else
            begin
                y_next = y_reg - x_reg;
            end
        end

        // dividing by (x << k) is dividing the pre-shifted value by x
        if (cmd.div_init)
        begin
            qn_next  = num_reg >> k_reg;
            qd_next  = NW'(den_reg) >> k_reg;
            rn_next  = '0;
            rd_next  = '0;
            cnt_next = CW'(NW - 1);
        end
        else if (cmd.div_step)
        begin
            rn_next  = step_n[2*NW:NW];
            qn_next  = step_n[NW-1:0];
            rd_next  = step_d[2*NW:NW];
            qd_next  = step_d[NW-1:0];
            cnt_next = cnt_reg - CW'(1);
        end

        if (cmd.out_load)
        begin
            out_next.result_numerator   = qn_wide[RES_NUM_WIDTH-1:0];
            out_next.result_denominator = qd_wide[RES_DEN_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        qn_reg   <= qn_next;
        qd_reg   <= qd_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/famr_ctrl.sv
// Controller: sequences multiply, GCD and divide steps and owns both handshakes.
`default_nettype none

module famr_ctrl
    import famr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire famr_sts_t sts,
    output famr_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVI = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       out_free;

    assign out_free  = !ovalid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_FIRST;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_M0;
                end
            end
            S_M0:
            begin
                cmd.mul_sel   = MUL_FIRST;
                cmd.prod_load = 1'b1;
                state_next    = S_M1;
            end
            S_M1:
            begin
                cmd.num_load  = 1'b1;
                cmd.mul_sel   = MUL_CROSS;
                cmd.prod_load = 1'b1;
                state_next    = S_M2;
            end
            S_M2:
            begin
                cmd.num_add   = 1'b1;
                cmd.mul_sel   = MUL_DEN;
                cmd.prod_load = 1'b1;
                state_next    = S_M3;
            end
            S_M3:
            begin
                cmd.den_load = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                cmd.gcd_init = 1'b1;
                state_next   = sts.is_zero ? S_FIN : S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/fraction_add_multiply_reduce_test.sv
// Self-checking testbench for fraction_add_multiply_reduce: random and corner fractions.
`timescale 1ns / 1ps

module fraction_add_multiply_reduce_test;
    import famr_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1900;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    famr_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    famr_out_t out_data;

    famr_in_t  pending_fractions[$];
    famr_out_t reduced_due[$];

    logic      in_xfer     = 1'b0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    int        stall_left  = 0;
    int        cycle_count = 0;
    int        errors      = 0;
    int        sum_count   = 0;
    int        prod_count  = 0;
    int        zero_count  = 0;
    int        match_count = 0;

    fraction_add_multiply_reduce i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Sum or product of the two fractions, divided through by the GCD.
    function automatic famr_out_t reduce_fraction(famr_in_t item);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] bn;
        logic [63:0] bd;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] div;
        famr_out_t   res;
        an  = 64'(item.a_numerator);
        ad  = 64'(item.a_denominator);
        bn  = 64'(item.b_numerator);
        bd  = 64'(item.b_denominator);
        den = ad * bd;
        if (item.action == ACT_ADD)
            num = an * bd + bn * ad;
        else
            num = an * bn;
        div = 64'd1;
        if (num != 0 && den != 0)
            div = common_divisor(num, den);
        res.result_numerator   = RES_NUM_WIDTH'(num / div);
        res.result_denominator = RES_DEN_WIDTH'(den / div);
        return res;
    endfunction

    function automatic void queue_fraction(logic act, logic [15:0] an, logic [15:0] ad,
                                           logic [15:0] bn, logic [15:0] bd);
        famr_in_t item;
        item.action        = act;
        item.a_numerator   = an;
        item.a_denominator = ad;
        item.b_numerator   = bn;
        item.b_denominator = bd;
        pending_fractions.push_back(item);
    endfunction

    // Mix of full-range, small, smooth and extreme values; factor forces a shared divisor.
    function automatic logic [15:0] pick_operand(bit allow_zero, int unsigned factor);
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'($urandom_range(1, 65535));
            4, 5:       v = 16'($urandom_range(1, 20));
            6, 7:       v = 16'($urandom_range(1, 255) * $urandom_range(1, 255));
            8:          v = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h8000;
            default:    v = allow_zero ? 16'd0 : 16'($urandom_range(1, 3));
        endcase
        if (factor > 1 && v != 0)
            v = 16'(factor * $urandom_range(1, 65535 / factor));
        return v;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_xfer)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_fractions.size() != 0)
            begin
                in_data  <= pending_fractions.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    case ($urandom_range(0, 4))
                        0, 1:    gap_left <= 0;
                        2, 3:    gap_left <= $urandom_range(1, 10);
                        default: gap_left <= $urandom_range(10, 200);
                    endcase
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: free-running, coin-toss, and long-stall phases in turn.
    always @(negedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n)
            out_ready <= 1'b0;
        else
            case (cycle_count[13:12])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_left == 0)
                    begin
                        stall_left <= $urandom_range(0, 60);
                        out_ready  <= 1'b1;
                    end
                    else
                    begin
                        stall_left <= stall_left - 1;
                        out_ready  <= 1'b0;
                    end
                end
            endcase
    end

    always @(posedge clk)
    begin
        famr_out_t want;
        famr_out_t got;
        in_xfer <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            want = reduce_fraction(in_data);
            reduced_due.push_back(want);
            if (in_data.action == ACT_ADD)
                sum_count++;
            else
                prod_count++;
            if (want.result_numerator == 0 || want.result_denominator == 0)
                zero_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = out_data;
            if (reduced_due.size() == 0)
            begin
                $error("unexpected result transfer: %0d / %0d",
                       got.result_numerator, got.result_denominator);
                errors++;
            end
            else
            begin
                want = reduced_due.pop_front();
                match_count++;
                if (got.result_numerator !== want.result_numerator)
                begin
                    $error("result_numerator: expected %0d, got %0d",
                           want.result_numerator, got.result_numerator);
                    errors++;
                end
                if (got.result_denominator !== want.result_denominator)
                begin
                    $error("result_denominator: expected %0d, got %0d",
                           want.result_denominator, got.result_denominator);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned factor;
        // corner cases
        queue_fraction(ACT_ADD, 16'd0, 16'd1, 16'd0, 16'd1);
        queue_fraction(ACT_MUL, 16'd0, 16'd3, 16'd5, 16'd4);
        queue_fraction(ACT_ADD, 16'd0, 16'd3, 16'd0, 16'd4);
        queue_fraction(ACT_ADD, 16'd1, 16'd2, 16'd1, 16'd2);
        queue_fraction(ACT_MUL, 16'd3, 16'd4, 16'd4, 16'd3);
        queue_fraction(ACT_ADD, 16'hffff, 16'd1, 16'hffff, 16'd1);
        queue_fraction(ACT_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        queue_fraction(ACT_MUL, 16'hffff, 16'd1, 16'hffff, 16'd1);
        queue_fraction(ACT_MUL, 16'd1, 16'hffff, 16'd1, 16'hffff);
        queue_fraction(ACT_ADD, 16'hffff, 16'hfffe, 16'hfffe, 16'hffff);
        queue_fraction(ACT_ADD, 16'd1, 16'hffff, 16'd1, 16'hfffe);
        queue_fraction(ACT_MUL, 16'hffff, 16'hfffe, 16'hfffe, 16'hffff);
        queue_fraction(ACT_ADD, 16'd0, 16'hffff, 16'hffff, 16'hffff);
        queue_fraction(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_fraction(ACT_ADD, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
        queue_fraction(ACT_MUL, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        // zero denominators pass through unreduced
        queue_fraction(ACT_ADD, 16'd5, 16'd0, 16'd3, 16'd7);
        queue_fraction(ACT_MUL, 16'd5, 16'd0, 16'd3, 16'd7);
        queue_fraction(ACT_ADD, 16'd2, 16'd0, 16'd3, 16'd0);

        repeat (RANDOM_ITEMS)
        begin
            factor = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 64) : 1;
            queue_fraction(1'($urandom_range(0, 1)),
                           pick_operand(1'b1, factor), pick_operand(1'b0, factor),
                           pick_operand(1'b1, factor), pick_operand(1'b0, factor));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_fractions.size() != 0 || in_valid || reduced_due.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        if (reduced_due.size() != 0)
        begin
            $error("%0d results never arrived", reduced_due.size());
            errors++;
        end
        $display("Checked %0d results: %0d sums and %0d products, %0d with a zero term.",
                 match_count, sum_count, prod_count, zero_count);
        if (errors == 0)
            $display("** fraction_add_multiply_reduce: PASSED **");
        else
            $display("** fraction_add_multiply_reduce: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("Timed out with %0d items still queued and %0d results owed.",
                 pending_fractions.size(), reduced_due.size());
        $display("** fraction_add_multiply_reduce: FAILED **");
        $finish;
    end

endmodule
